/* sv/sh2d_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sh2d_pkg
// types, encoding table and field codes for the sh2 instruction decoder
// ----------------------------------------------------------------------------
package sh2d_pkg;

  localparam int NUM_OPS   = 70;
  localparam int OPW_W     = 16;
  localparam int OPID_W    = 7;
  localparam int REG_W     = 4;
  localparam int DISP_W    = 8;
  localparam int OUT_W     = 32;

  // which word fields an encoding supplies
  typedef logic [3:0] use_t;
  localparam use_t USE_NONE = 4'b0000;
  localparam use_t USE_DST  = 4'b0001;  // rn from bits 11..8
  localparam use_t USE_SRC  = 4'b0010;  // rm from bits 7..4
  localparam use_t USE_SRH  = 4'b0100;  // rm from bits 11..8
  localparam use_t USE_DSP  = 4'b1000;  // displacement from bits 7..0
  localparam use_t USE_DS   = USE_DST | USE_SRC;

  typedef enum logic [2:0] {
    MEM_NONE   = 3'd0,
    MEM_RD_S8  = 3'd1,
    MEM_RD_S16 = 3'd2,
    MEM_RD_U32 = 3'd3,
    MEM_WR_U8  = 3'd4,
    MEM_WR_U16 = 3'd5,
    MEM_WR_U32 = 3'd6
  } mem_kind_t;

  typedef enum logic [1:0] {
    FLOW_NONE   = 2'd0,
    FLOW_CALL   = 2'd1,
    FLOW_BRANCH = 2'd2,
    FLOW_RETURN = 2'd3
  } flow_kind_t;

  typedef struct packed {
    logic [OPW_W-1:0] mask;
    logic [OPW_W-1:0] pattern;
    use_t             uses;
    mem_kind_t        mem;
    flow_kind_t       flow;
    logic             delay;
  } op_entry_t;

  // result fields, msb first so the packed image matches tdata lsb-first order
  typedef struct packed {
    logic              delay_slot;
    flow_kind_t        flow_kind;
    mem_kind_t         mem_kind;
    logic [DISP_W-1:0] displacement;
    logic [REG_W-1:0]  src_reg;
    logic [REG_W-1:0]  dest_reg;
    logic [OPID_W-1:0] op_id;
    logic              recognized;
  } dec_result_t;

  localparam op_entry_t OP_TABLE [NUM_OPS] = '{
    '{16'hF0FF, 16'h000A, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // sts mach
    '{16'hF0FF, 16'h001A, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // sts macl
    '{16'hF0FF, 16'h002A, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // sts pr
    '{16'hF0FF, 16'h0002, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // stc sr
    '{16'hF0FF, 16'h0012, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // stc gbr
    '{16'hF0FF, 16'h0022, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // stc vbr
    '{16'hF0FF, 16'h400A, USE_SRH, MEM_NONE,   FLOW_NONE,   1'b0},  // lds mach
    '{16'hF0FF, 16'h401A, USE_SRH, MEM_NONE,   FLOW_NONE,   1'b0},  // lds macl
    '{16'hF0FF, 16'h402A, USE_SRH, MEM_NONE,   FLOW_NONE,   1'b0},  // lds pr
    '{16'hF0FF, 16'h4002, USE_DST, MEM_WR_U32, FLOW_NONE,   1'b0},  // sts.l mach
    '{16'hF0FF, 16'h4012, USE_DST, MEM_WR_U32, FLOW_NONE,   1'b0},  // sts.l macl
    '{16'hF0FF, 16'h4006, USE_SRH, MEM_RD_U32, FLOW_NONE,   1'b0},  // lds.l mach
    '{16'hF0FF, 16'h4016, USE_SRH, MEM_RD_U32, FLOW_NONE,   1'b0},  // lds.l macl
    '{16'hF0FF, 16'h400E, USE_SRH, MEM_NONE,   FLOW_NONE,   1'b0},  // ldc sr
    '{16'hF0FF, 16'h401E, USE_SRH, MEM_NONE,   FLOW_NONE,   1'b0},  // ldc gbr
    '{16'hF0FF, 16'h402E, USE_SRH, MEM_NONE,   FLOW_NONE,   1'b0},  // ldc vbr
    '{16'hF0FF, 16'h4003, USE_DST, MEM_WR_U32, FLOW_NONE,   1'b0},  // stc.l sr
    '{16'hF0FF, 16'h4013, USE_DST, MEM_WR_U32, FLOW_NONE,   1'b0},  // stc.l gbr
    '{16'hF0FF, 16'h4023, USE_DST, MEM_WR_U32, FLOW_NONE,   1'b0},  // stc.l vbr
    '{16'hF0FF, 16'h4007, USE_SRH, MEM_RD_U32, FLOW_NONE,   1'b0},  // ldc.l sr
    '{16'hF0FF, 16'h4017, USE_SRH, MEM_RD_U32, FLOW_NONE,   1'b0},  // ldc.l gbr
    '{16'hF0FF, 16'h4027, USE_SRH, MEM_RD_U32, FLOW_NONE,   1'b0},  // ldc.l vbr
    '{16'hF00F, 16'h6004, USE_DS,  MEM_RD_S8,  FLOW_NONE,   1'b0},  // mov.b @rm+
    '{16'hF00F, 16'h2004, USE_DS,  MEM_WR_U8,  FLOW_NONE,   1'b0},  // mov.b @-rn
    '{16'hF00F, 16'h2005, USE_DS,  MEM_WR_U16, FLOW_NONE,   1'b0},  // mov.w @-rn
    '{16'hFF00, 16'hC700, USE_DSP, MEM_NONE,   FLOW_NONE,   1'b0},  // mova
    '{16'hF00F, 16'h6007, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // not
    '{16'hF00F, 16'h6008, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // swap.b
    '{16'hF00F, 16'h6009, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // swap.w
    '{16'hF00F, 16'h600A, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // negc
    '{16'hF00F, 16'h600B, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // neg
    '{16'hF00F, 16'h200A, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // xor rm,rn
    '{16'hF00F, 16'h2007, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // div0s
    '{16'hF00F, 16'h200C, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // cmp/str
    '{16'hF00F, 16'h200E, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // mulu.w
    '{16'hF00F, 16'h200F, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // muls.w
    '{16'hFF00, 16'hCA00, USE_DSP, MEM_NONE,   FLOW_NONE,   1'b0},  // xor #imm
    '{16'hFF00, 16'hCB00, USE_DSP, MEM_NONE,   FLOW_NONE,   1'b0},  // or #imm
    '{16'hFF00, 16'hC300, USE_DSP, MEM_NONE,   FLOW_CALL,   1'b0},  // trapa
    '{16'hFFFF, 16'h0019, USE_NONE, MEM_NONE,  FLOW_NONE,   1'b0},  // div0u
    '{16'hFFFF, 16'h001B, USE_NONE, MEM_NONE,  FLOW_NONE,   1'b0},  // sleep
    '{16'hFFFF, 16'h002B, USE_NONE, MEM_NONE,  FLOW_RETURN, 1'b1},  // rte
    '{16'hF00F, 16'h3004, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // div1
    '{16'hF00F, 16'h3005, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // dmulu.l
    '{16'hF00F, 16'h300A, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // subc
    '{16'hF00F, 16'h300B, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // subv
    '{16'hF00F, 16'h300D, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // dmuls.l
    '{16'hF00F, 16'h300E, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // addc
    '{16'hF00F, 16'h300F, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // addv
    '{16'hF0FF, 16'h4004, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // rotl
    '{16'hF0FF, 16'h4005, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // rotr
    '{16'hF0FF, 16'h4025, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // rotcr
    '{16'hF0FF, 16'h4020, USE_DST, MEM_NONE,   FLOW_NONE,   1'b0},  // shal
    '{16'hF00F, 16'h0007, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // mul.l
    '{16'hF00F, 16'h000F, USE_DS,  MEM_RD_U32, FLOW_NONE,   1'b0},  // mac.l
    '{16'hF00F, 16'h400F, USE_DS,  MEM_RD_S16, FLOW_NONE,   1'b0},  // mac.w
    '{16'hF0FF, 16'h0003, USE_DST, MEM_NONE,   FLOW_CALL,   1'b1},  // bsrf
    '{16'hF0FF, 16'h0023, USE_DST, MEM_NONE,   FLOW_BRANCH, 1'b1},  // braf
    '{16'hF0FF, 16'h401B, USE_DST, MEM_WR_U8,  FLOW_NONE,   1'b0},  // tas.b
    '{16'hF00F, 16'h200D, USE_DS,  MEM_NONE,   FLOW_NONE,   1'b0},  // xtrct
    '{16'hFF00, 16'hC000, USE_DSP, MEM_WR_U8,  FLOW_NONE,   1'b0},  // mov.b r0,@(d,gbr)
    '{16'hFF00, 16'hC100, USE_DSP, MEM_WR_U16, FLOW_NONE,   1'b0},  // mov.w r0,@(d,gbr)
    '{16'hFF00, 16'hC200, USE_DSP, MEM_WR_U32, FLOW_NONE,   1'b0},  // mov.l r0,@(d,gbr)
    '{16'hFF00, 16'hC400, USE_DSP, MEM_RD_S8,  FLOW_NONE,   1'b0},  // mov.b @(d,gbr),r0
    '{16'hFF00, 16'hC500, USE_DSP, MEM_RD_S16, FLOW_NONE,   1'b0},  // mov.w @(d,gbr),r0
    '{16'hFF00, 16'hC600, USE_DSP, MEM_RD_U32, FLOW_NONE,   1'b0},  // mov.l @(d,gbr),r0
    '{16'hFF00, 16'hCC00, USE_DSP, MEM_NONE,   FLOW_NONE,   1'b0},  // tst.b
    '{16'hFF00, 16'hCD00, USE_DSP, MEM_NONE,   FLOW_NONE,   1'b0},  // and.b
    '{16'hFF00, 16'hCE00, USE_DSP, MEM_NONE,   FLOW_NONE,   1'b0},  // xor.b
    '{16'hFF00, 16'hCF00, USE_DSP, MEM_NONE,   FLOW_NONE,   1'b0}   // or.b
  };

endpackage
`default_nettype wire

/* sv/sh2_instruction_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sh2_instruction_decoder
// decodes one 16-bit sh2 opcode per transaction into register, displacement,
// memory-access and control-flow fields
// ----------------------------------------------------------------------------
// usage
//   s_tvalid/s_tready/s_tdata carry one opcode per transaction.
//   m_tvalid/m_tready/m_tdata carry one decode result per opcode, in order.
//   an opcode sits in the input register while the table match and
//   priority pick run, then the result lands in the output register,
//   which drives m_tvalid and m_tdata.
//   throughput is one opcode per cycle while the receiver keeps m_tready
//   high; the rate is set by the single table match between the registers.
//   when the receiver stalls, the output register holds its result and the
//   input register keeps the next opcode; s_tready drops only when both
//   are full, and rises in the same cycle the receiver takes the result.
//   reset (rst, synchronous) empties both registers; no table state exists.
//   unknown opcodes give recognized = 0 with every other field zero.
// ----------------------------------------------------------------------------
module sh2_instruction_decoder
  import sh2d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [15:0] s_tdata,   // opcode_word[15:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // recognized[0], op_id[7:1], dest_reg[11:8], src_reg[15:12],
  // displacement[23:16], mem_kind[26:24], flow_kind[28:27],
  // delay_slot[29], zero[31:30]
  output      logic [31:0] m_tdata
);

  logic             in_valid;
  logic [OPW_W-1:0] in_word;
  logic             out_valid;
  dec_result_t      out_res;
  dec_result_t      dec;
  logic             advance;
  logic             s_take;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign s_take   = s_tvalid && s_tready;

  // match every entry, lowest index wins by scanning downward
  always_comb begin
    op_entry_t ent;
    dec = '0;
    for (int k = NUM_OPS - 1; k >= 0; k--) begin
      ent = OP_TABLE[k];
      if ((in_word & ent.mask) == ent.pattern) begin
        dec                = '0;
        dec.recognized     = 1'b1;
        dec.op_id          = OPID_W'(k);
        dec.mem_kind       = ent.mem;
        dec.flow_kind      = ent.flow;
        dec.delay_slot     = ent.delay;
        if ((ent.uses & USE_DST) != USE_NONE) begin
          dec.dest_reg = in_word[11:8];
        end
        if ((ent.uses & USE_SRC) != USE_NONE) begin
          dec.src_reg = in_word[7:4];
        end
        if ((ent.uses & USE_SRH) != USE_NONE) begin
          dec.src_reg = in_word[11:8];
        end
        if ((ent.uses & USE_DSP) != USE_NONE) begin
          dec.displacement = in_word[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_take) begin
      in_word <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance && in_valid) begin
      out_res <= dec;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W - $bits(dec_result_t))'(0), out_res};

`ifndef SYNTHESIS
  // an unmatched word carries nothing but zeros
  a_unrec_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.recognized) |-> (out_res == '0))
    else $error("unrecognized result has nonzero fields");

  // delay slot only on control-flow forms
  a_delay_flow: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.delay_slot) |-> (out_res.flow_kind != FLOW_NONE))
    else $error("delay slot without control flow");

  // an accepted opcode is held in the input register next cycle
  a_take_held: assert property (@(posedge clk) disable iff (rst)
    s_take |=> in_valid)
    else $error("accepted opcode lost");

  // a full input register with a free output stage moves to the output
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> (m_tvalid && out_res == $past(dec)))
    else $error("decode result not registered");
`endif

endmodule
`default_nettype wire

/* verif/sh2_decode_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sh2_decode_checker
// watches both stream channels of the sh2 instruction decoder, computes the
// expected decode of every accepted opcode from its own encoding list and
// compares each result transaction field by field, in order
// ----------------------------------------------------------------------------
module sh2_decode_checker
  import sh2d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  output int unsigned      failures,
  output int unsigned      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENC_COUNT = 70;

  // which opcode fields an encoding hands to the result
  localparam logic [3:0] TAKE_NONE  = 4'b0000;
  localparam logic [3:0] TAKE_RN    = 4'b0001;  // bits 11..8 to dest_reg
  localparam logic [3:0] TAKE_RM    = 4'b0010;  // bits 7..4 to src_reg
  localparam logic [3:0] TAKE_RM_HI = 4'b0100;  // bits 11..8 to src_reg
  localparam logic [3:0] TAKE_DISP  = 4'b1000;  // bits 7..0 to displacement
  localparam logic [3:0] TAKE_RN_RM = TAKE_RN | TAKE_RM;

  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] bits;
    logic [3:0]  takes;
    mem_kind_t   mem;
    flow_kind_t  flow;
    logic        slot;
  } encoding_t;

  typedef struct {
    logic [15:0] word;
    dec_result_t res;
  } decode_entry_t;

  // first match wins, position is the operation number
  localparam encoding_t ENCODINGS [ENC_COUNT] = '{
    '{16'hF0FF, 16'h000A, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h001A, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h002A, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h0002, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h0012, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h0022, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h400A, TAKE_RM_HI, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h401A, TAKE_RM_HI, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h402A, TAKE_RM_HI, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4002, TAKE_RN,    MEM_WR_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4012, TAKE_RN,    MEM_WR_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4006, TAKE_RM_HI, MEM_RD_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4016, TAKE_RM_HI, MEM_RD_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h400E, TAKE_RM_HI, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h401E, TAKE_RM_HI, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h402E, TAKE_RM_HI, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4003, TAKE_RN,    MEM_WR_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4013, TAKE_RN,    MEM_WR_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4023, TAKE_RN,    MEM_WR_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4007, TAKE_RM_HI, MEM_RD_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4017, TAKE_RM_HI, MEM_RD_U32, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4027, TAKE_RM_HI, MEM_RD_U32, FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h6004, TAKE_RN_RM, MEM_RD_S8,  FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h2004, TAKE_RN_RM, MEM_WR_U8,  FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h2005, TAKE_RN_RM, MEM_WR_U16, FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC700, TAKE_DISP,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h6007, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h6008, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h6009, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h600A, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h600B, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h200A, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h2007, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h200C, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h200E, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h200F, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hCA00, TAKE_DISP,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hCB00, TAKE_DISP,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC300, TAKE_DISP,  MEM_NONE,   FLOW_CALL,   1'b0},
    '{16'hFFFF, 16'h0019, TAKE_NONE,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFFFF, 16'h001B, TAKE_NONE,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFFFF, 16'h002B, TAKE_NONE,  MEM_NONE,   FLOW_RETURN, 1'b1},
    '{16'hF00F, 16'h3004, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h3005, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h300A, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h300B, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h300D, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h300E, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h300F, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4004, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4005, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4025, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h4020, TAKE_RN,    MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h0007, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h000F, TAKE_RN_RM, MEM_RD_U32, FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h400F, TAKE_RN_RM, MEM_RD_S16, FLOW_NONE,   1'b0},
    '{16'hF0FF, 16'h0003, TAKE_RN,    MEM_NONE,   FLOW_CALL,   1'b1},
    '{16'hF0FF, 16'h0023, TAKE_RN,    MEM_NONE,   FLOW_BRANCH, 1'b1},
    '{16'hF0FF, 16'h401B, TAKE_RN,    MEM_WR_U8,  FLOW_NONE,   1'b0},
    '{16'hF00F, 16'h200D, TAKE_RN_RM, MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC000, TAKE_DISP,  MEM_WR_U8,  FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC100, TAKE_DISP,  MEM_WR_U16, FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC200, TAKE_DISP,  MEM_WR_U32, FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC400, TAKE_DISP,  MEM_RD_S8,  FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC500, TAKE_DISP,  MEM_RD_S16, FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hC600, TAKE_DISP,  MEM_RD_U32, FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hCC00, TAKE_DISP,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hCD00, TAKE_DISP,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hCE00, TAKE_DISP,  MEM_NONE,   FLOW_NONE,   1'b0},
    '{16'hFF00, 16'hCF00, TAKE_DISP,  MEM_NONE,   FLOW_NONE,   1'b0}
  };

  decode_entry_t decode_q[$];

  function automatic dec_result_t decode_opcode(logic [15:0] word);
    dec_result_t r;
    r = '0;
    for (int i = 0; i < ENC_COUNT; i++) begin
      if ((word & ENCODINGS[i].mask) == ENCODINGS[i].bits) begin
        r.recognized = 1'b1;
        r.op_id      = 7'(i);
        if ((ENCODINGS[i].takes & TAKE_RN) != 0) r.dest_reg = word[11:8];
        if ((ENCODINGS[i].takes & TAKE_RM) != 0) r.src_reg = word[7:4];
        if ((ENCODINGS[i].takes & TAKE_RM_HI) != 0) r.src_reg = word[11:8];
        if ((ENCODINGS[i].takes & TAKE_DISP) != 0) r.displacement = word[7:0];
        r.mem_kind   = ENCODINGS[i].mem;
        r.flow_kind  = ENCODINGS[i].flow;
        r.delay_slot = ENCODINGS[i].slot;
        return r;
      end
    end
    return r;
  endfunction

  task automatic compare_decode(decode_entry_t want, dec_result_t got);
    if (got.recognized !== want.res.recognized) begin
      $error("recognized: expected %0d, actual %0d (opcode %h)",
             want.res.recognized, got.recognized, want.word);
      failures++;
    end
    if (got.op_id !== want.res.op_id) begin
      $error("op_id: expected %0d, actual %0d (opcode %h)",
             want.res.op_id, got.op_id, want.word);
      failures++;
    end
    if (got.dest_reg !== want.res.dest_reg) begin
      $error("dest_reg: expected %0d, actual %0d (opcode %h)",
             want.res.dest_reg, got.dest_reg, want.word);
      failures++;
    end
    if (got.src_reg !== want.res.src_reg) begin
      $error("src_reg: expected %0d, actual %0d (opcode %h)",
             want.res.src_reg, got.src_reg, want.word);
      failures++;
    end
    if (got.displacement !== want.res.displacement) begin
      $error("displacement: expected %h, actual %h (opcode %h)",
             want.res.displacement, got.displacement, want.word);
      failures++;
    end
    if (got.mem_kind !== want.res.mem_kind) begin
      $error("mem_kind: expected %0d, actual %0d (opcode %h)",
             want.res.mem_kind, got.mem_kind, want.word);
      failures++;
    end
    if (got.flow_kind !== want.res.flow_kind) begin
      $error("flow_kind: expected %0d, actual %0d (opcode %h)",
             want.res.flow_kind, got.flow_kind, want.word);
      failures++;
    end
    if (got.delay_slot !== want.res.delay_slot) begin
      $error("delay_slot: expected %0d, actual %0d (opcode %h)",
             want.res.delay_slot, got.delay_slot, want.word);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    decode_entry_t item;
    if (rst) begin
      decode_q.delete();
      failures = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        item.word = s_tdata;
        item.res  = decode_opcode(s_tdata);
        decode_q.push_back(item);
      end
      if (m_tvalid && m_tready) begin
        if (decode_q.size() == 0) begin
          $error("result transaction %h with no opcode outstanding", m_tdata);
          failures++;
        end else begin
          compare_decode(decode_q.pop_front(), dec_result_t'(m_tdata[29:0]));
        end
      end
    end
    pending = decode_q.size();
  end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the sh2 instruction decoder: directed corner opcodes,
// then mostly decodable random opcodes, with bursty input and a patterned
// output stall; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int STUCK_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [3:0]  PREFIXES [6]    = '{4'h0, 4'h2, 4'h3, 4'h4, 4'h6, 4'hC};
  localparam logic [15:0] FIXED_WORDS [3] = '{16'h0019, 16'h001B, 16'h002B};

  // all-zero / all-one words, fixed encodings and near misses, register
  // fields at both ends, immediates at both ends
  localparam logic [15:0] DIRECTED_WORDS [22] = '{
    16'h0000, 16'hFFFF, 16'h0019, 16'h001B, 16'h002B, 16'h0039,
    16'h0F2B, 16'h4F0A, 16'h402E, 16'h4F27, 16'h0F03, 16'h0023,
    16'h4F1B, 16'h6FF4, 16'h2FFF, 16'h400F, 16'h0F0F, 16'h4025,
    16'hC3FF, 16'hC700, 16'hCFFF, 16'hC000
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int unsigned failures;
  int unsigned pending;
  int unsigned stuck_cycles = 0;
  int unsigned stall_left   = 0;
  logic [7:0]  ready_pat    = 8'hFF;

  always #5 clk = ~clk;

  sh2_instruction_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sh2_decode_checker decode_chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .failures (failures),
    .pending  (pending)
  );

  // receiver: rotating ready pattern, reloaded whenever its random countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(100, 300);
      if ($urandom_range(0, 2) == 0) begin
        ready_pat <= 8'hFF;
      end else begin
        ready_pat <= 8'($urandom) | 8'h01;
      end
    end else begin
      stall_left <= stall_left - 1;
      ready_pat  <= {ready_pat[0], ready_pat[7:1]};
    end
    m_tready <= ready_pat[0];
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // mostly words near real encodings, some fully random
  function automatic logic [15:0] random_opcode();
    logic [15:0] w;
    int unsigned sel;
    int unsigned bit_idx;
    w   = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      w = FIXED_WORDS[$urandom_range(0, 2)];
      if ($urandom_range(0, 2) == 0) begin
        bit_idx    = $urandom_range(0, 15);
        w[bit_idx] = ~w[bit_idx];
      end
    end else if (sel < 85) begin
      w[15:12] = PREFIXES[$urandom_range(0, 5)];
      if ($urandom_range(0, 9) < 7) w[7:4] = 4'($urandom_range(0, 2));
    end
    return w;
  endfunction

  task automatic send_word(input logic [15:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold off until every outstanding opcode has its result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int unsigned burst;
    burst = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_WORDS[i]) send_word(DIRECTED_WORDS[i]);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                            : $urandom_range(1, 24);
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      send_word(random_opcode());
      burst--;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
sv/sh2d_pkg.sv
sv/sh2_instruction_decoder.sv
verif/sh2_decode_checker.sv
verif/tb_top.sv
